// ===== src/isotp_frame_segmenter_defines.svh =====
// assertion helpers used by isotp_seg_core
`ifndef ISOTP_FRAME_SEGMENTER_DEFINES_SVH
`define ISOTP_FRAME_SEGMENTER_DEFINES_SVH

// implication checked in the same cycle
`define ISOTP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the next cycle
`define ISOTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/isotp_seg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package isotp_seg_pkg;

  // protocol control information codes
  localparam logic [7:0] PCI_SINGLE = 8'h00;
  localparam logic [7:0] PCI_FIRST  = 8'h10;
  localparam logic [7:0] PCI_CONSEC = 8'h20;

  localparam logic [7:0]  PAD_RESET     = 8'hAA;
  localparam logic [3:0]  SEQ_RESET     = 4'd1;
  localparam logic [11:0] CAP_NORMAL    = 12'd7;
  localparam logic [11:0] CAP_EXTENDED  = 12'd6;

  typedef enum logic [1:0] {
    CFG_EXTENDED_ADDRESSING = 2'd0,
    CFG_TARGET_ADDRESS      = 2'd1,
    CFG_PAD_VALUE           = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic       extended_addressing;
    logic [7:0] target_address;
    logic [7:0] pad_value;
  } seg_cfg_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [11:0] message_length;
  } seg_item_t;

  typedef struct packed {
    logic [7:0][7:0] frame_bytes;
    logic            final_frame;
  } seg_frame_t;

endpackage
`default_nettype wire

// ===== src/isotp_seg_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module isotp_seg_in_reg
  import isotp_seg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [11:0] in_message_length,
  input  wire logic        advance,
  output logic             item_valid,
  output seg_item_t        item
);

  logic      item_valid_r;
  seg_item_t item_r;

  // held item blocks the input until the core takes it
  assign in_stall   = item_valid_r && !advance;
  assign item_valid = item_valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.data_byte      <= in_data_byte;
      item_r.message_length <= in_message_length;
    end
  end

endmodule
`default_nettype wire

// ===== src/isotp_seg_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "isotp_frame_segmenter_defines.svh"
module isotp_seg_core
  import isotp_seg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic go,
  input  seg_item_t item,
  input  seg_cfg_t  cfg,
  output logic      emit,
  output seg_frame_t frame
);

  logic [11:0]     taken_r, taken_nxt;
  logic [2:0]      fill_r, fill_nxt;
  logic [3:0]      seq_r, seq_nxt;
  logic [7:0][7:0] store_r;

  logic [11:0]     len_eff;
  logic [11:0]     cap;
  logic [11:0]     taken_inc;
  logic [2:0]      pos;
  logic [7:0][7:0] cur;
  logic [3:0]      seq_adv;
  logic            last;

  always_comb begin
    // zero length counts as one byte
    len_eff = (item.message_length == 12'd0) ? 12'd1 : item.message_length;
    cap     = cfg.extended_addressing ? CAP_EXTENDED : CAP_NORMAL;
    cur     = store_r;
    pos     = fill_r;
    seq_adv = seq_r;

    // open a new frame: optional address byte, then pci
    if (fill_r == 3'd0) begin
      pos = 3'd0;
      if (cfg.extended_addressing) begin
        cur[0] = cfg.target_address;
        pos    = 3'd1;
      end
      if (taken_r == 12'd0) begin
        if (len_eff <= cap) begin
          cur[pos] = PCI_SINGLE | {4'd0, len_eff[3:0]};
          pos      = pos + 3'd1;
        end else begin
          cur[pos]        = PCI_FIRST | {4'd0, len_eff[11:8]};
          cur[pos + 3'd1] = len_eff[7:0];
          pos             = pos + 3'd2;
        end
      end else begin
        cur[pos] = PCI_CONSEC | {4'd0, seq_r};
        seq_adv  = seq_r + 4'd1;
        pos      = pos + 3'd1;
      end
    end

    cur[pos]  = item.data_byte;
    taken_inc = taken_r + 12'd1;
    last      = (taken_inc >= len_eff);
    emit      = last || (pos == 3'd7);

    for (int i = 0; i < 8; i++) begin
      frame.frame_bytes[i] = (3'(i) <= pos) ? cur[i] : cfg.pad_value;
    end
    frame.final_frame = last;

    taken_nxt = taken_inc;
    seq_nxt   = seq_adv;
    fill_nxt  = pos + 3'd1;
    if (emit) begin
      fill_nxt = 3'd0;
    end
    if (last) begin
      taken_nxt = 12'd0;
      seq_nxt   = SEQ_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= 12'd0;
      fill_r  <= 3'd0;
      seq_r   <= SEQ_RESET;
    end else if (go) begin
      taken_r <= taken_nxt;
      fill_r  <= fill_nxt;
      seq_r   <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      store_r <= cur;
    end
  end

  `ISOTP_ASSERT_NEXT(a_last_clears_count, go && emit && last, taken_r == 12'd0 && seq_r == SEQ_RESET, "message end did not clear counters")
  `ISOTP_ASSERT_SAME(a_mid_frame_full, go && emit && !last, pos == 3'd7, "frame emitted before full")
  `ISOTP_ASSERT_NEXT(a_open_frame_kept, go && !emit, fill_r != 3'd0, "open frame lost its fill position")

endmodule
`default_nettype wire

// ===== src/isotp_frame_segmenter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// isotp transmit segmenter: cuts a message into 8-byte can frames
// input channel: one payload byte per transfer (in_data_byte) with the total
//   message length (in_message_length) repeated on every byte of the message
// result channel: one frame per transfer, bytes out_frame_b0..b7 and
//   out_final_frame on the last frame of the message
// configuration: cfg_index / cfg_data written when cfg_valid and cfg_ready;
//   cfg_ready is always high, writes belong to idle periods only
// frame path: a byte that closes a frame passes the input register, then the
//   frame build into the output register, which drives out_valid
// throughput: one byte per cycle unless out_stall holds a frame; the frame
//   build is a single pass from the input register to the output register
// stall: when out_stall holds a frame, the item in the input register waits
//   and in_stall rises, so at most one item sits between the two sides
// reset: synchronous active-low rst_n clears the counters, closes any open
//   frame, sets the sequence number to 1 and the pad byte to 0xAA
module isotp_frame_segmenter
  import isotp_seg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // payload input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [11:0] in_message_length,
  // frame output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_frame_b0,
  output logic [7:0]       out_frame_b1,
  output logic [7:0]       out_frame_b2,
  output logic [7:0]       out_frame_b3,
  output logic [7:0]       out_frame_b4,
  output logic [7:0]       out_frame_b5,
  output logic [7:0]       out_frame_b6,
  output logic [7:0]       out_frame_b7,
  output logic             out_final_frame,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  seg_cfg_t   cfg_r;
  seg_item_t  item;
  logic       item_valid;
  logic       advance;
  logic       go;
  logic       emit;
  seg_frame_t frame;
  logic       out_valid_r;
  seg_frame_t out_frame_r;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.extended_addressing <= 1'b0;
      cfg_r.target_address      <= 8'd0;
      cfg_r.pad_value           <= PAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_EXTENDED_ADDRESSING: cfg_r.extended_addressing <= cfg_data[0];
        CFG_TARGET_ADDRESS:      cfg_r.target_address      <= cfg_data;
        CFG_PAD_VALUE:           cfg_r.pad_value           <= cfg_data;
        default:                 ;
      endcase
    end
  end

  // the core may step whenever the output register is free or draining
  assign advance = !out_valid_r || !out_stall;
  assign go      = item_valid && advance;

  isotp_seg_in_reg u_in_reg (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_message_length (in_message_length),
    .advance           (advance),
    .item_valid        (item_valid),
    .item              (item)
  );

  isotp_seg_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (item),
    .cfg   (cfg_r),
    .emit  (emit),
    .frame (frame)
  );

  // output register: loads a finished frame, holds it while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= go && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      out_frame_r <= frame;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_b0    = out_frame_r.frame_bytes[0];
  assign out_frame_b1    = out_frame_r.frame_bytes[1];
  assign out_frame_b2    = out_frame_r.frame_bytes[2];
  assign out_frame_b3    = out_frame_r.frame_bytes[3];
  assign out_frame_b4    = out_frame_r.frame_bytes[4];
  assign out_frame_b5    = out_frame_r.frame_bytes[5];
  assign out_frame_b6    = out_frame_r.frame_bytes[6];
  assign out_frame_b7    = out_frame_r.frame_bytes[7];
  assign out_final_frame = out_frame_r.final_frame;

endmodule
`default_nettype wire
